// ===== rtl/core/rdsc_pkg.sv =====
// Shared constants, types and the digit character table of the radix digit string converter.
`default_nettype none

package rdsc_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_DIGITS = 64;

  // Quotient bits retired per clock by the datapath divider
  localparam int STEP_BITS  = 4;
  localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int QW         = STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [7:0] FMT_HEX_LOWER = 8'h78;  // 'x'
  localparam logic [7:0] FMT_POINTER   = 8'h70;  // 'p'

  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_A_LOWER = 7'h61;
  localparam logic [6:0] CHAR_A_UPPER = 7'h41;

  typedef struct packed {
    logic load;
    logic step;
    logic read;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic digit_end;
    logic quot_zero;
    logic cnt_last;
    logic cnt_one;
  } dp_sts_t;

  function automatic logic [6:0] digit_ascii(input logic [3:0] d, input logic lower);
    logic [6:0] base;
    base = lower ? CHAR_A_LOWER : CHAR_A_UPPER;
    if (d < 4'd10) begin
      digit_ascii = CHAR_ZERO + 7'(d);
    end else begin
      digit_ascii = base + 7'(d - 4'd10);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/radix_digit_string_converter_top.sv =====
// Top level of the radix digit string converter.
// A request is taken when start is high while busy is low. The value is divided by
// the radix four quotient bits per clock; after the last digit the string is read
// back from the digit store most significant first, one digit at a time, each shown
// for one cycle with result_valid high and last_digit marking the final one. A
// request holds busy until its final digit has been shown (at most 64 digits). The
// receiver cannot stall the output: every digit must be taken in the cycle
// result_valid is high.
`default_nettype none

module radix_digit_string_converter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] value,
  input  wire logic [4:0]  radix,
  input  wire logic [7:0]  format_char,
  output logic             result_valid,
  output logic [6:0]       digit_char,
  output logic             last_digit
);
  import rdsc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rdsc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  rdsc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .radix       (radix),
    .format_char (format_char),
    .cmd         (cmd),
    .sts         (sts),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rdsc_datapath.sv =====
// Datapath: radix divider, digit store, digit counter and character encoding.
`default_nettype none

module rdsc_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [63:0]       value,
  input  wire logic [4:0]        radix,
  input  wire logic [7:0]        format_char,
  input  wire rdsc_pkg::dp_cmd_t cmd,
  output rdsc_pkg::dp_sts_t      sts,
  output logic [6:0]             digit_char,
  output logic                   last_digit
);
  import rdsc_pkg::*;

  logic [QW-1:0]         quot;
  logic [3:0]            rem;
  logic [4:0]            rdx;
  logic                  lower;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0]      count;
  logic [3:0]            rd_digit;
  logic [3:0]            store [MAX_DIGITS];

  logic [QW-1:0]         q_work;
  logic [3:0]            r_work;
  logic [4:0]            trial;
  logic [4:0]            rdx_sat;
  logic                  digit_end;
  logic [CNT_W-1:0]      rd_pos;

  // Restoring division, several quotient bits per clock
  always_comb begin
    q_work = quot;
    r_work = rem;
    trial  = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial  = {r_work, q_work[QW-1]};
      q_work = {q_work[QW-2:0], 1'b0};
      if (trial >= rdx) begin
        trial     = trial - rdx;
        q_work[0] = 1'b1;
      end
      r_work = trial[3:0];
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      rdx_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      rdx_sat = RADIX_MAX;
    end else begin
      rdx_sat = radix;
    end
  end

  assign digit_end = (step_cnt == STEP_CNT_W'(STEPS - 1));
  assign rd_pos    = count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      quot     <= '0;
      rem      <= '0;
      step_cnt <= '0;
      count    <= '0;
    end else if (cmd.load) begin
      quot     <= QW'(value[VALUE_BITS-1:0]);
      rem      <= '0;
      step_cnt <= '0;
      count    <= '0;
    end else if (cmd.step) begin
      quot <= q_work;
      if (digit_end) begin
        rem      <= '0;
        step_cnt <= '0;
        count    <= count + CNT_W'(1);
      end else begin
        rem      <= r_work;
        step_cnt <= step_cnt + STEP_CNT_W'(1);
      end
    end else if (cmd.emit) begin
      count <= count - CNT_W'(1);
    end
  end

  // Hold the request's radix and letter case
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdx   <= rdx_sat;
      lower <= (format_char == FMT_HEX_LOWER) || (format_char == FMT_POINTER);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && digit_end) begin
      store[count[IDX_W-1:0]] <= r_work;
    end
    if (cmd.read) begin
      rd_digit <= store[rd_pos[IDX_W-1:0]];
    end
  end

  assign sts.digit_end = digit_end;
  assign sts.quot_zero = (q_work == '0);
  assign sts.cnt_last  = (count == CNT_W'(MAX_DIGITS - 1));
  assign sts.cnt_one   = (count == CNT_W'(1));

  assign digit_char = digit_ascii(rd_digit, lower);
  assign last_digit = sts.cnt_one;

endmodule

`default_nettype wire

// ===== rtl/core/rdsc_ctrl.sv =====
// Controller: sequences load, division, store read-back and digit output.
`default_nettype none

module rdsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire rdsc_pkg::dp_sts_t sts,
  output rdsc_pkg::dp_cmd_t      cmd,
  output logic                   busy,
  output logic                   result_valid
);
  import rdsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        // stop once the quotient runs out or the store is full
        if (sts.digit_end && (sts.quot_zero || sts.cnt_last)) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.read   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit   = 1'b1;
        state_next = sts.cnt_one ? ST_IDLE : ST_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy         = (state != ST_IDLE);
  assign result_valid = (state == ST_OUT);

endmodule

`default_nettype wire

// ===== rtl/core/rdsc_checker.sv =====
// Port-level assertions for the radix digit string converter, bound to the top level.
`default_nettype none

module rdsc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       result_valid,
  input wire logic [6:0] digit_char,
  input wire logic       last_digit
);

  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result outside a busy period");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_digit_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_digit) |=> (busy && !result_valid))
    else $error("digits not separated or request ended early");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_digit) |=> !busy)
    else $error("busy held after final digit");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (digit_char >= 7'h30 && digit_char <= 7'h66))
    else $error("digit character out of range");

endmodule

bind radix_digit_string_converter_top rdsc_checker u_rdsc_checker (.*);

`default_nettype wire

// ===== tb/tb_radix_digit_string_converter_top.sv =====
// Self-checking testbench of the radix digit string converter: predicted digit strings against DUT.
module tb_radix_digit_string_converter_top;
  import rdsc_pkg::*;

  localparam logic [7:0] FMT_HEX_UPPER = 8'h58;  // 'X'
  localparam logic [7:0] FMT_DECIMAL   = 8'h64;  // 'd'
  localparam logic [7:0] FMT_UNSIGNED  = 8'h75;  // 'u'
  localparam logic [7:0] FMT_OCTAL     = 8'h6F;  // 'o'
  localparam logic [7:0] FMT_PTR_UPPER = 8'h50;  // 'P'
  localparam logic [7:0] FMT_NEAR_X    = 8'h79;  // 'y'
  localparam logic [7:0] FMT_NEAR_P    = 8'h71;  // 'q'
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};
  localparam int SETTLE_CYCLES         = 64;
  localparam int DRAIN_LIMIT           = 5000;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } digit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] value = '0;
  logic [4:0]  radix = 5'd10;
  logic [7:0]  format_char = FMT_DECIMAL;
  logic        busy;
  logic        result_valid;
  logic [6:0]  digit_char;
  logic        last_digit;

  digit_t expected_digits[$];
  int     mismatches = 0;

  radix_digit_string_converter_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .radix       (radix),
    .format_char (format_char),
    .result_valid(result_valid),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Convert one request into its expected digit string, most significant first
  function automatic void predict_digits(input logic [63:0] v, input logic [4:0] r,
                                         input logic [7:0] f);
    string      lower_set = "0123456789abcdef";
    string      upper_set = "0123456789ABCDEF";
    logic [3:0] rems[MAX_DIGITS];
    logic [63:0] quot;
    logic [63:0] base;
    int         count;
    logic       lower;
    digit_t     d;
    base  = (r < RADIX_MIN) ? 64'(RADIX_MIN) : (r > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(r);
    lower = (f == FMT_HEX_LOWER) || (f == FMT_POINTER);
    quot  = v;
    count = 0;
    do begin
      rems[count] = 4'(quot % base);
      quot = quot / base;
      count++;
    end while (quot != 0 && count < MAX_DIGITS);
    for (int k = count; k > 0; k--) begin
      d.ch   = lower ? 7'(lower_set[rems[k-1]]) : 7'(upper_set[rems[k-1]]);
      d.last = (k == 1);
      expected_digits.push_back(d);
    end
  endfunction

  // Called at a rising edge; leaves start high once the request is taken
  task automatic send_request(input logic [63:0] v, input logic [4:0] r, input logic [7:0] f);
    start       <= 1'b1;
    value       <= v;
    radix       <= r;
    format_char <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_digits(v, r, f);
  endtask

  task automatic idle_burst(input bit after_busy);
    start <= 1'b0;
    if (after_busy) begin
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    start <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (expected_digits.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic logic [7:0] pick_format();
    case ($urandom_range(0, 9))
      0, 1:    pick_format = FMT_HEX_LOWER;
      2:       pick_format = FMT_POINTER;
      3:       pick_format = FMT_HEX_UPPER;
      4:       pick_format = FMT_DECIMAL;
      5:       pick_format = FMT_PTR_UPPER;
      6:       pick_format = FMT_OCTAL;
      default: pick_format = 8'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_radix();
    if ($urandom_range(0, 7) == 0) pick_radix = 5'($urandom);
    else pick_radix = 5'($urandom_range(2, 16));
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 15))
      0:       pick_value = '0;
      1:       pick_value = ALL_ONES;
      2:       pick_value = 64'($urandom_range(0, 40));
      default: pick_value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  always @(posedge clk) begin : check_digits
    digit_t want;
    if (!rst && result_valid) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit 0x%0h last=%0b", digit_char, last_digit));
      end else begin
        want = expected_digits.pop_front();
        if (digit_char !== want.ch)
          report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h", digit_char, want.ch));
        if (last_digit !== want.last)
          report_mismatch($sformatf("last_digit %0b, expected %0b", last_digit, want.last));
      end
    end
  end

  task automatic test_directed();
    send_request('0, 5'd10, FMT_DECIMAL);
    send_request('0, 5'd2, FMT_HEX_LOWER);
    send_request(ALL_ONES, 5'd2, FMT_HEX_LOWER);
    send_request(ALL_ONES, 5'd16, FMT_HEX_LOWER);
    send_request(ALL_ONES, 5'd16, FMT_POINTER);
    send_request(ALL_ONES, 5'd16, FMT_HEX_UPPER);
    send_request(ALL_ONES, 5'd10, FMT_UNSIGNED);
    send_request(ALL_ONES, 5'd3, FMT_OCTAL);
    send_request(64'd1, 5'd2, 8'h00);
    send_request(64'd15, 5'd16, 8'hFF);
    send_request(64'd16, 5'd16, FMT_HEX_LOWER);
    // out-of-range radix saturates at either end
    send_request(64'd255, 5'd0, FMT_DECIMAL);
    send_request(64'd255, 5'd1, FMT_DECIMAL);
    send_request(64'd255, 5'd17, FMT_HEX_LOWER);
    send_request(64'd255, 5'd31, FMT_HEX_UPPER);
    send_request(64'h8000_0000_0000_0000, 5'd2, FMT_DECIMAL);
    send_request(64'hDEAD_BEEF_CAFE_F00D, 5'd16, FMT_POINTER);
    send_request(64'hDEAD_BEEF_CAFE_F00D, 5'd16, FMT_PTR_UPPER);
    send_request(64'd12345, 5'd7, FMT_NEAR_X);
    send_request(64'h5555_5555_5555_5555, 5'd4, FMT_NEAR_P);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 5'd8, FMT_HEX_LOWER);
    send_request(64'd10, 5'd11, FMT_HEX_LOWER);
    send_request(64'd10, 5'd11, FMT_HEX_UPPER);
    send_request(64'd124, 5'd5, FMT_DECIMAL);
    wait_drained();
  endtask

  task automatic test_random_requests(input int count);
    bit quiet;
    quiet = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 10 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_request(pick_value(), pick_radix(), pick_format());
      if (!quiet) begin
        case ($urandom_range(0, 3))
          0: idle_burst(1'b0);
          1: idle_burst(1'b1);
          default: ;
        endcase
      end
    end
  endtask

  // Hold the next request back until every pending digit has come out
  task automatic test_pause_until_drained();
    send_request(ALL_ONES, 5'd16, pick_format());
    send_request(pick_value(), pick_radix(), pick_format());
    wait_drained();
    repeat ($urandom_range(1, 8)) @(posedge clk);
    send_request(pick_value(), pick_radix(), pick_format());
  endtask

  task automatic test_back_to_back(input int count);
    for (int i = 0; i < count; i++)
      send_request(pick_value(), pick_radix(), pick_format());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_requests(73);
    test_pause_until_drained();
    test_back_to_back(20);
    wait_drained();
    if (expected_digits.size() != 0)
      report_mismatch($sformatf("%0d expected digits never came", expected_digits.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
